// ===== rtl/bs3_pkg.sv =====
// ============================================================================
// bs3_pkg
// Shared types and constants for the 3x3 box smoothing filter: sample and
// sum widths, reciprocal constants for the rounded mean, register indexes.
// ============================================================================
package bs3_pkg;

    // Sample format (signed Q8.8)
    localparam int SAMPLE_BITS = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam int FRAME_WIDTH_BITS  = 7;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int FRAME_WIDTH_RESET  = 64;
    localparam int FRAME_HEIGHT_RESET = 64;
    localparam int FRAME_HEIGHT_MAX   = 4096;
    localparam int FRAME_DIM_MIN      = 2;

    // Row counter runs two past the last row during the drain
    localparam int ROW_W = 13;

    // Datapath widths
    localparam int CS_W  = SAMPLE_BITS + 2;   // sum of up to 3 samples
    localparam int SUM_W = SAMPLE_BITS + 4;   // sum of up to 9 samples
    localparam int MAG_W = SAMPLE_BITS + 3;   // rounded-up magnitude

    // Reciprocal multiply: floor(y / d) = (y * ceil(2^K / d)) >> K, exact
    // for y < 2^MAG_W when K = MAG_W + 4.
    localparam int REC_SHIFT = MAG_W + 4;
    localparam int REC_W     = REC_SHIFT - 1;
    localparam int PROD_W    = MAG_W + REC_W;

    localparam logic [REC_W-1:0] RECIP_4 = REC_W'(2 ** (REC_SHIFT - 2));
    localparam logic [REC_W-1:0] RECIP_3 = REC_W'((2 ** REC_SHIFT + 2) / 3);
    localparam logic [REC_W-1:0] RECIP_9 = REC_W'((2 ** REC_SHIFT + 8) / 9);

    // Rounding bias added to the magnitude before the scaled divide
    localparam logic [SUM_W-1:0] BIAS_4 = SUM_W'(2);
    localparam logic [SUM_W-1:0] BIAS_6 = SUM_W'(3);
    localparam logic [SUM_W-1:0] BIAS_9 = SUM_W'(4);

    // Number of cells under the window
    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    // What the mean pipeline needs to know about one result
    typedef struct packed {
        logic     incl_left;
        logic     incl_new;
        div_sel_t div;
        logic     last;
    } emit_t;

    // One accepted item on its way to the row stores and the window
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          top_ok;
        logic                          bot_ok;
        logic                          emit;
        emit_t                         info;
    } item_t;

endpackage

// ===== rtl/bs3_ram.sv =====
// ============================================================================
// bs3_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data held while the read enable is low.
// ============================================================================
module bs3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bs3_scan.sv =====
// ============================================================================
// bs3_scan
// Raster scan control: frame registers, input column/row counters, drain
// detection, and per-item decode of which result (if any) the item causes.
// ============================================================================
module bs3_scan #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bs3_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bs3_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [bs3_pkg::SAMPLE_BITS-1:0] height_in,
    input  logic                                 flush,
    input  logic                                 s1_pop,
    output logic                                 rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
    output logic                                 s1_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]         s1_addr,
    output bs3_pkg::item_t                       s1_item
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int W_RESET = (MAX_WIDTH < bs3_pkg::FRAME_WIDTH_RESET) ?
                             MAX_WIDTH : bs3_pkg::FRAME_WIDTH_RESET;

    logic [W_W-1:0]               width_reg;
    logic [bs3_pkg::ROW_W-1:0]    height_reg;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [bs3_pkg::ROW_W-1:0]    row_reg, row_next;
    logic                         s1_valid_reg;
    logic [COL_W-1:0]             s1_addr_reg;
    bs3_pkg::item_t               s1_item_reg;

    logic [bs3_pkg::FRAME_WIDTH_BITS-1:0]  cfg_w;
    logic [bs3_pkg::FRAME_HEIGHT_BITS-1:0] cfg_h;
    logic [W_W-1:0]               width_clamped;
    logic [bs3_pkg::ROW_W-1:0]    height_clamped;

    logic free, accept, take, draining;
    logic emit_edge, emit_mid, first_row, last_row, rows3, cols3, last_cell;
    logic row_is1, row_is2, row_is_h, row_is_h1, col_zero, col_ge2, col_wrap;
    bs3_pkg::item_t item;

    // Register value clamping
    always_comb
    begin
        cfg_w = cfg_data[bs3_pkg::FRAME_WIDTH_BITS-1:0];
        cfg_h = cfg_data[bs3_pkg::FRAME_HEIGHT_BITS-1:0];

        if (32'(cfg_w) < bs3_pkg::FRAME_DIM_MIN)
            width_clamped = W_W'(bs3_pkg::FRAME_DIM_MIN);
        else if (32'(cfg_w) > MAX_WIDTH)
            width_clamped = W_W'(MAX_WIDTH);
        else
            width_clamped = W_W'(cfg_w);

        if (32'(cfg_h) < bs3_pkg::FRAME_DIM_MIN)
            height_clamped = bs3_pkg::ROW_W'(bs3_pkg::FRAME_DIM_MIN);
        else if (32'(cfg_h) > bs3_pkg::FRAME_HEIGHT_MAX)
            height_clamped = bs3_pkg::ROW_W'(bs3_pkg::FRAME_HEIGHT_MAX);
        else
            height_clamped = bs3_pkg::ROW_W'(cfg_h);
    end

    // Item decode
    always_comb
    begin
        free     = !s1_valid_reg || s1_pop;
        accept   = in_valid && free;
        draining = (row_reg >= height_reg);
        take     = accept && (draining || !flush);

        col_zero  = (col_reg == '0);
        col_ge2   = (col_reg >= COL_W'(2));
        row_is1   = (row_reg == bs3_pkg::ROW_W'(1));
        row_is2   = (row_reg == bs3_pkg::ROW_W'(2));
        row_is_h  = (row_reg == height_reg);
        row_is_h1 = (row_reg == height_reg + 1'b1);

        // Right-edge cell of the row two back, or the cell one column back in the row one back
        emit_edge = col_zero && (row_reg >= bs3_pkg::ROW_W'(2));
        emit_mid  = !col_zero && (row_reg != '0);
        first_row = emit_edge ? row_is2 : row_is1;
        last_row  = emit_edge ? row_is_h1 : row_is_h;
        rows3     = !first_row && !last_row;
        cols3     = emit_mid && col_ge2;
        last_cell = emit_edge && row_is_h1;

        item.sample         = draining ? '0 : height_in;
        item.top_ok         = !row_is1;
        item.bot_ok         = !draining;
        item.emit           = emit_edge || emit_mid;
        item.info.incl_left = emit_edge || col_ge2;
        item.info.incl_new  = emit_mid;
        item.info.last      = last_cell;
        if (rows3 && cols3)
            item.info.div = bs3_pkg::DIV_BY_9;
        else if (rows3 || cols3)
            item.info.div = bs3_pkg::DIV_BY_6;
        else
            item.info.div = bs3_pkg::DIV_BY_4;

        col_wrap = (W_W'(col_reg) + 1'b1 == width_reg);
        if (last_cell)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_wrap)
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= W_W'(W_RESET);
            height_reg   <= bs3_pkg::ROW_W'(bs3_pkg::FRAME_HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cfg_write)
            begin
                unique case (cfg_index)
                    bs3_pkg::REG_FRAME_WIDTH:
                    begin
                        width_reg <= width_clamped;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    bs3_pkg::REG_FRAME_HEIGHT:
                    begin
                        height_reg <= height_clamped;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                        col_reg <= col_reg;
                    end
                endcase
            end
            else if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (free)
            begin
                s1_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_addr_reg <= col_reg;
            s1_item_reg <= item;
        end
    end

    assign in_stall = !free;
    assign rd_en    = take;
    assign rd_addr  = col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_item  = s1_item_reg;

endmodule

// ===== rtl/bs3_mean.sv =====
// ============================================================================
// bs3_mean
// Rounded 3x3 mean pipeline: window sum, biased magnitude, reciprocal
// multiply, sign restore, output register.
// ============================================================================
module bs3_mean (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   ready,
    input  logic signed [bs3_pkg::CS_W-1:0]        left_sum,
    input  logic signed [bs3_pkg::CS_W-1:0]        mid_sum,
    input  logic signed [bs3_pkg::CS_W-1:0]        right_sum,
    input  bs3_pkg::emit_t                         info,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [bs3_pkg::SAMPLE_BITS-1:0] height_out,
    output logic                                   end_of_frame
);

    // Operand stage
    logic                              s2_valid_reg;
    logic signed [bs3_pkg::CS_W-1:0]   s2_left_reg, s2_mid_reg, s2_right_reg;
    bs3_pkg::emit_t                    s2_info_reg;
    // Sum stage
    logic                              s3_valid_reg;
    logic signed [bs3_pkg::SUM_W-1:0]  s3_sum_reg;
    bs3_pkg::emit_t                    s3_info_reg;
    // Scaled magnitude stage
    logic                              s4_valid_reg;
    logic [bs3_pkg::MAG_W-1:0]         s4_y_reg;
    logic                              s4_neg_reg;
    bs3_pkg::div_sel_t                 s4_div_reg;
    logic                              s4_last_reg;
    // Quotient stage
    logic                              s5_valid_reg;
    logic [bs3_pkg::SAMPLE_BITS-1:0]   s5_q_reg;
    logic                              s5_neg_reg;
    logic                              s5_last_reg;
    // Output register
    logic                              out_valid_reg;
    logic [bs3_pkg::SAMPLE_BITS-1:0]   out_height_reg;
    logic                              out_last_reg;

    logic en3, en4, en5, en_out;
    logic signed [bs3_pkg::SUM_W-1:0] sum;
    logic [bs3_pkg::SUM_W-1:0]        bias, y_full;
    logic [bs3_pkg::MAG_W-1:0]        y;
    logic [bs3_pkg::REC_W-1:0]        recip;
    logic [bs3_pkg::PROD_W-1:0]       prod;
    logic                             neg;

    assign en_out = !out_valid_reg || !out_stall;
    assign en5    = !s5_valid_reg || en_out;
    assign en4    = !s4_valid_reg || en5;
    assign en3    = !s3_valid_reg || en4;
    assign ready  = !s2_valid_reg || en3;

    always_comb
    begin
        sum = bs3_pkg::SUM_W'(s2_mid_reg)
            + (s2_info_reg.incl_left ? bs3_pkg::SUM_W'(s2_left_reg) : '0)
            + (s2_info_reg.incl_new  ? bs3_pkg::SUM_W'(s2_right_reg) : '0);
    end

    // |sum| plus bias in one adder: bias - sum for a negative sum
    always_comb
    begin
        neg = s3_sum_reg[bs3_pkg::SUM_W-1];
        unique case (s3_info_reg.div)
            bs3_pkg::DIV_BY_4: bias = bs3_pkg::BIAS_4;
            bs3_pkg::DIV_BY_6: bias = bs3_pkg::BIAS_6;
            bs3_pkg::DIV_BY_9: bias = bs3_pkg::BIAS_9;
            default:           bias = bs3_pkg::BIAS_4;
        endcase
        y_full = neg ? (bias - s3_sum_reg) : (s3_sum_reg + bias);
        // x/6 = floor(x/2)/3 leaves a halved magnitude for the six-cell case
        if (s3_info_reg.div == bs3_pkg::DIV_BY_6)
            y = y_full[bs3_pkg::MAG_W:1];
        else
            y = y_full[bs3_pkg::MAG_W-1:0];
    end

    always_comb
    begin
        unique case (s4_div_reg)
            bs3_pkg::DIV_BY_4: recip = bs3_pkg::RECIP_4;
            bs3_pkg::DIV_BY_6: recip = bs3_pkg::RECIP_3;
            bs3_pkg::DIV_BY_9: recip = bs3_pkg::RECIP_9;
            default:           recip = bs3_pkg::RECIP_4;
        endcase
        prod = bs3_pkg::PROD_W'(s4_y_reg) * bs3_pkg::PROD_W'(recip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready)
                s2_valid_reg <= push;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
            if (en5)
                s5_valid_reg <= s4_valid_reg;
            if (en_out)
                out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            s2_left_reg  <= left_sum;
            s2_mid_reg   <= mid_sum;
            s2_right_reg <= right_sum;
            s2_info_reg  <= info;
        end
        if (en3)
        begin
            s3_sum_reg  <= sum;
            s3_info_reg <= s2_info_reg;
        end
        if (en4)
        begin
            s4_y_reg    <= y;
            s4_neg_reg  <= neg;
            s4_div_reg  <= s3_info_reg.div;
            s4_last_reg <= s3_info_reg.last;
        end
        if (en5)
        begin
            s5_q_reg    <= prod[bs3_pkg::REC_SHIFT +: bs3_pkg::SAMPLE_BITS];
            s5_neg_reg  <= s4_neg_reg;
            s5_last_reg <= s4_last_reg;
        end
        if (en_out)
        begin
            out_height_reg <= s5_neg_reg ? ('0 - s5_q_reg) : s5_q_reg;
            out_last_reg   <= s5_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign height_out   = out_height_reg;
    assign end_of_frame = out_last_reg;

endmodule

// ===== rtl/box_smooth_3x3.sv =====
// ============================================================================
// box_smooth_3x3
// 3x3 box mean over a raster height map, rounded to nearest, with two row
// stores in RAM and a column-sum window; frames drain with flush items.
// ============================================================================
// Path: the input transfer that completes a result's window (one row plus one
//   cell later in items) passes the item, operand, sum, magnitude, quotient and output registers.
// Throughput: one input transfer per cycle while in_stall is low; the row stores
//   are read once and written once per item, on separate RAM ports.
// Reset: counters, frame registers (64 x 64) and valid bits clear; row store
//   contents are undefined and only reach rows outside the map.
module box_smooth_3x3 #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bs3_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [bs3_pkg::CFG_DATA_W-1:0]         cfg_data,
    // Sample input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [bs3_pkg::SAMPLE_BITS-1:0] height_in,
    input  logic                                   flush,
    // Smoothed output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [bs3_pkg::SAMPLE_BITS-1:0] height_out,
    output logic                                   end_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                                rd_en;
    logic [COL_W-1:0]                    rd_addr;
    logic                                s1_valid;
    logic [COL_W-1:0]                    s1_addr;
    bs3_pkg::item_t                      s1_item;
    logic                                s1_pop;
    logic                                mean_ready;
    logic [bs3_pkg::SAMPLE_BITS-1:0]     older_rd, newer_rd;
    logic signed [bs3_pkg::CS_W-1:0]     col_sum_new;
    logic signed [bs3_pkg::CS_W-1:0]     win_left_reg, win_mid_reg;

    // Registers take writes any time; the host only writes while idle.
    assign cfg_ready = 1'b1;

    // Stage 0: counters, decode, row store read at the input column.
    bs3_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .height_in (height_in),
        .flush     (flush),
        .s1_pop    (s1_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1_addr   (s1_addr),
        .s1_item   (s1_item)
    );

    // Row stores. The older store takes the newer store's old value, the
    // newer store takes the sample: a read-modify-write of one column per
    // item. Consecutive items always touch different columns (width >= 2),
    // so a read never overlaps the write-back of the same entry; the only
    // exception, the first item after a frame restart, reads rows that
    // the window masks off anyway.
    bs3_ram #(
        .WIDTH (bs3_pkg::SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_row (
        .clk     (clk),
        .wr_en   (s1_pop),
        .wr_addr (s1_addr),
        .wr_data (newer_rd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (older_rd)
    );

    bs3_ram #(
        .WIDTH (bs3_pkg::SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_newer_row (
        .clk     (clk),
        .wr_en   (s1_pop),
        .wr_addr (s1_addr),
        .wr_data (s1_item.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (newer_rd)
    );

    // Stage 1: the new window column. Every emission that uses a column
    // shares its output row, so the top/bottom row masks are applied once
    // here and the window keeps only masked column sums.
    always_comb
    begin
        col_sum_new = bs3_pkg::CS_W'(signed'(newer_rd))
            + (s1_item.top_ok ? bs3_pkg::CS_W'(signed'(older_rd)) : '0)
            + (s1_item.bot_ok ? bs3_pkg::CS_W'(s1_item.sample) : '0);
    end

    // Items without a result only shift the window; items with one wait
    // for the mean pipeline.
    assign s1_pop = s1_valid && (!s1_item.emit || mean_ready);

    // Window: column sums two back (left) and one back (mid). The mid column
    // is the center for a right-edge result and for an inner one.
    always_ff @(posedge clk)
    begin
        if (s1_pop)
        begin
            win_left_reg <= win_mid_reg;
            win_mid_reg  <= col_sum_new;
        end
    end

    // Stages 2-6: window sum, rounding, reciprocal divide, output register.
    bs3_mean u_mean (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_pop && s1_item.emit),
        .ready        (mean_ready),
        .left_sum     (win_left_reg),
        .mid_sum      (win_mid_reg),
        .right_sum    (col_sum_new),
        .info         (s1_item.info),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height_out   (height_out),
        .end_of_frame (end_of_frame)
    );

endmodule
